>>> hdl/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types, codes and slot arithmetic for the buddy allocator.
// ----------------------------------------------------------------------------
package bal_pkg;

	// Pool geometry: offsets are 16 bits, free bits are packed 32 to a word
	localparam int POOL_ORDER  = 16;
	localparam int WORD_LG     = 5;
	localparam int SPLIT_ORDER = POOL_ORDER - WORD_LG;
	localparam int SLOT_W      = POOL_ORDER + 1;
	localparam logic [16:0] POOL_LIMIT = 17'h10000;

	// Command field codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_ALLOC    = 2'd0;
	localparam logic [1:0] ST_NOSPACE  = 2'd1;
	localparam logic [1:0] ST_FREED    = 2'd2;
	localparam logic [1:0] ST_IGNORED  = 2'd3;

	// Configuration register indexes
	localparam logic REG_POOL_BASE  = 1'b0;
	localparam logic REG_POOL_BYTES = 1'b1;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DECODE,
		OP_CHECK,
		OP_CARVE_INIT,
		OP_SCAN,
		OP_PICK,
		OP_RD,
		OP_WR,
		OP_RESULT
	} dp_op_t;

	typedef enum logic [1:0] {
		TGT_CARVE,
		TGT_SPLIT,
		TGT_MERGE,
		TGT_FINAL
	} tgt_t;

	typedef struct packed {
		dp_op_t     op;
		tgt_t       tgt;
		logic       wbit;
		logic [1:0] status;
		logic       cfg_we;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic ord_ok;
		logic free_ok;
		logic carve_more;
		logic scan_hit;
		logic scan_last;
		logic split_more;
		logic merge_more;
		logic mate_free;
		logic out_busy;
	} dp_stat_t;

	// Heap-style slot of an aligned block, offset by one so that each order
	// below the word split fills whole words
	function automatic logic [SLOT_W-1:0] slot_of(input logic [4:0] o, input logic [15:0] off);
		logic [4:0] sh;
		sh = 5'(POOL_ORDER) - o;
		return (SLOT_W'(1) << sh) + ({1'b0, off} >> o);
	endfunction

endpackage

>>> hdl/buddy_allocator.sv
// ----------------------------------------------------------------------------
// buddy_allocator
// Buddy allocator over a pool of up to 64 KiB with per-order free bitmaps.
// ----------------------------------------------------------------------------
// An item is taken in the idle cycle and passes through decode, check and
// routing. An allocate then scans one order per cycle from the requested
// order up to the top order, picks a free block, and runs a split check,
// read and write per split and a last split check. A free runs a merge
// check, read and test per merge step, ends the merge on a check (or on a
// read and test when the last buddy turns out busy), and marks the final
// block free in a read and a write. The done state loads the result register,
// and holds while a waiting result beat sees m_tready low. These steps follow
// the read-modify-write of the free-bit store. The next item is taken while a
// result beat still waits. After reset and after each write of pool_bytes the
// pool is carved into free blocks (carve init, then a check, read and write
// per block, a last check), while no item or configuration beat is accepted.
module buddy_allocator
	import bal_pkg::*;
#(
	parameter int MIN_ORDER = 5,
	parameter int MAX_ORDER = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // req_bytes[31:0], free_addr[63:32]
	input  logic [0:0]  s_tuser,   // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // block_addr[31:0]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index[0]),
		.stat      (stat),
		.cmd       (cmd)
	);

	bal_dp #(
		.MIN_ORDER (MIN_ORDER),
		.MAX_ORDER (MAX_ORDER)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> hdl/bal_ctrl.sv
// ----------------------------------------------------------------------------
// bal_ctrl
// Sequencer for decode, search, split, merge and pool carving.
// ----------------------------------------------------------------------------
module bal_ctrl
	import bal_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_index,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_CARVE_INIT,
		S_CARVE_CHK,
		S_CARVE_RD,
		S_CARVE_WR,
		S_IDLE,
		S_DECODE,
		S_CHECK,
		S_ROUTE,
		S_SCAN,
		S_PICK,
		S_SPLIT_CHK,
		S_SPLIT_RD,
		S_SPLIT_WR,
		S_MERGE_CHK,
		S_MERGE_RD,
		S_MERGE_TEST,
		S_FINAL_RD,
		S_FINAL_WR,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] res_q;

	// Handshakes open only while idle; configuration wins a tie
	assign cfg_ready = (state_q == S_IDLE);
	assign s_tready  = (state_q == S_IDLE) && !cfg_valid;

	// Decode state into datapath commands
	always_comb begin
		cmd        = '0;
		cmd.op     = OP_NOP;
		cmd.tgt    = TGT_CARVE;
		cmd.status = res_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.cfg_we = cfg_valid;
				if (s_tvalid && !cfg_valid) begin
					cmd.op = OP_LOAD;
				end
			end
			S_CARVE_INIT: cmd.op = OP_CARVE_INIT;
			S_CARVE_RD: begin
				cmd.op  = OP_RD;
				cmd.tgt = TGT_CARVE;
			end
			S_CARVE_WR: begin
				cmd.op   = OP_WR;
				cmd.tgt  = TGT_CARVE;
				cmd.wbit = 1'b1;
			end
			S_DECODE: cmd.op = OP_DECODE;
			S_CHECK:  cmd.op = OP_CHECK;
			S_SCAN:   cmd.op = OP_SCAN;
			S_PICK:   cmd.op = OP_PICK;
			S_SPLIT_RD: begin
				cmd.op  = OP_RD;
				cmd.tgt = TGT_SPLIT;
			end
			S_SPLIT_WR: begin
				cmd.op   = OP_WR;
				cmd.tgt  = TGT_SPLIT;
				cmd.wbit = 1'b1;
			end
			S_MERGE_RD: begin
				cmd.op  = OP_RD;
				cmd.tgt = TGT_MERGE;
			end
			S_MERGE_TEST: begin
				cmd.tgt = TGT_MERGE;
				if (stat.mate_free) begin
					cmd.op = OP_WR;
				end
			end
			S_FINAL_RD: begin
				cmd.op  = OP_RD;
				cmd.tgt = TGT_FINAL;
			end
			S_FINAL_WR: begin
				cmd.op   = OP_WR;
				cmd.tgt  = TGT_FINAL;
				cmd.wbit = 1'b1;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.op = OP_RESULT;
				end
			end
			default: cmd.op = OP_NOP;
		endcase
	end

	// Advance state and latch the result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CARVE_INIT;
			res_q   <= ST_NOSPACE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == REG_POOL_BYTES) begin
							state_q <= S_CARVE_INIT;
						end
					end else if (s_tvalid) begin
						state_q <= S_DECODE;
					end
				end
				S_CARVE_INIT: state_q <= S_CARVE_CHK;
				S_CARVE_CHK:  state_q <= stat.carve_more ? S_CARVE_RD : S_IDLE;
				S_CARVE_RD:   state_q <= S_CARVE_WR;
				S_CARVE_WR:   state_q <= S_CARVE_CHK;
				S_DECODE:     state_q <= S_CHECK;
				S_CHECK:      state_q <= S_ROUTE;
				S_ROUTE: begin
					if (!stat.is_free) begin
						if (stat.ord_ok) begin
							state_q <= S_SCAN;
						end else begin
							res_q   <= ST_NOSPACE;
							state_q <= S_DONE;
						end
					end else if (stat.free_ok) begin
						state_q <= S_MERGE_CHK;
					end else begin
						res_q   <= ST_IGNORED;
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (stat.scan_hit) begin
						state_q <= S_PICK;
					end else if (stat.scan_last) begin
						res_q   <= ST_NOSPACE;
						state_q <= S_DONE;
					end
				end
				S_PICK: state_q <= S_SPLIT_CHK;
				S_SPLIT_CHK: begin
					if (stat.split_more) begin
						state_q <= S_SPLIT_RD;
					end else begin
						res_q   <= ST_ALLOC;
						state_q <= S_DONE;
					end
				end
				S_SPLIT_RD:   state_q <= S_SPLIT_WR;
				S_SPLIT_WR:   state_q <= S_SPLIT_CHK;
				S_MERGE_CHK:  state_q <= stat.merge_more ? S_MERGE_RD : S_FINAL_RD;
				S_MERGE_RD:   state_q <= S_MERGE_TEST;
				S_MERGE_TEST: state_q <= stat.mate_free ? S_MERGE_CHK : S_FINAL_RD;
				S_FINAL_RD:   state_q <= S_FINAL_WR;
				S_FINAL_WR: begin
					res_q   <= ST_FREED;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/bal_dp.sv
// ----------------------------------------------------------------------------
// bal_dp
// Free-bit store, search logic, operand registers and result register.
// ----------------------------------------------------------------------------
module bal_dp
	import bal_pkg::*;
#(
	parameter int MIN_ORDER = 5,
	parameter int MAX_ORDER = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [63:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic [1:0]  m_tuser
);

	localparam int TOP = (MAX_ORDER < POOL_ORDER) ? MAX_ORDER : POOL_ORDER;
	localparam int D   = 1 << (POOL_ORDER + 1 - MIN_ORDER - WORD_LG);
	localparam int AW  = (D > 1) ? $clog2(D) : 1;

	function automatic logic [5:0] bitlen(input logic [31:0] v);
		logic [5:0] n;
		n = '0;
		for (int k = 0; k < 32; k++) begin
			if (v[k]) n = 6'(k + 1);
		end
		return n;
	endfunction

	// Configuration and operand registers
	logic [31:0] base_q;
	logic [16:0] bytes_q;
	logic        cmd_q;
	logic [31:0] req_q;
	logic [31:0] addr_q;
	logic [5:0]  ord_q;
	logic        ord_ok_q;
	logic        lt_base_q;
	logic [31:0] off32_q;
	logic        free_ok_q;
	logic [4:0]  j_q;
	logic [4:0]  i_q;
	logic [15:0] off_q;
	logic [16:0] rem_q;

	// Store and read path
	logic [31:0]   mem [D];
	logic [31:0]   mem_rd_q;
	logic          nz_rd_q;
	logic [D-1:0]  nz_q;
	logic [31:0]   w0_q;
	logic [AW-1:0] t_word_q;
	logic [4:0]    t_bit_q;

	// Result register
	logic        m_tvalid_q;
	logic [1:0]  m_status_q;
	logic [31:0] m_addr_q;

	logic [31:0]       req_m1;
	logic [5:0]        dec_ord;
	logic [16:0]       pw;
	logic [5:0]        rem_len;
	logic [4:0]        co;
	logic [16:0]       co_pw;
	logic [4:0]        im1;
	logic [SLOT_W-1:0] tslot;
	logic [AW-1:0]     tgt_word;
	logic [4:0]        tgt_bit;
	logic [D-1:0]      wmask;
	logic [AW-1:0]     scan_sel;
	logic              scan_mem_hit;
	logic [31:0]       omask;
	logic              w0_hit;
	logic [AW-1:0]     rd_addr;
	logic [31:0]       eff;
	logic [31:0]       pick_src;
	logic [4:0]        pick_p;
	logic              pick_any;
	logic [SLOT_W-1:0] pick_slot;
	logic [SLOT_W-1:0] pick_b;
	logic [15:0]       pick_off;
	logic [31:0]       new_word;
	logic              wr_en;

	// Size decode: round up to an order
	always_comb begin
		req_m1  = req_q - 32'd1;
		dec_ord = (req_q <= (32'd1 << MIN_ORDER)) ? 6'(MIN_ORDER) : bitlen(req_m1);
		pw      = 17'd1 << ord_q[4:0];
	end

	// Carve step: largest block that fits in the remainder
	always_comb begin
		rem_len = bitlen({15'd0, rem_q}) - 6'd1;
		co      = (rem_len > 6'(TOP)) ? 5'(TOP) : rem_len[4:0];
		co_pw   = 17'd1 << co;
		im1     = i_q - 5'd1;
	end

	// Target slot for a read-modify-write
	always_comb begin
		unique case (cmd.tgt)
			TGT_CARVE: tslot = slot_of(co, off_q);
			TGT_SPLIT: tslot = slot_of(im1, off_q | (16'd1 << im1));
			TGT_MERGE: tslot = slot_of(i_q, off_q ^ (16'd1 << i_q));
			TGT_FINAL: tslot = slot_of(i_q, off_q);
			default:   tslot = slot_of(i_q, off_q);
		endcase
		tgt_word = tslot[WORD_LG +: AW];
		tgt_bit  = tslot[WORD_LG-1:0];
	end

	// Search: highest nonempty word of the current order, or the masked head word
	always_comb begin
		wmask    = '0;
		scan_sel = '0;
		for (int w = 0; w < D; w++) begin
			if (int'(j_q) <= SPLIT_ORDER) begin
				wmask[w] = ((w >> (SPLIT_ORDER - int'(j_q))) == 1);
			end
			if (nz_q[w] && wmask[w]) scan_sel = AW'(w);
		end
		scan_mem_hit = |(nz_q & wmask);
		for (int k = 0; k < 32; k++) begin
			omask[k] = ((k >> (POOL_ORDER - int'(j_q))) == 1);
		end
		w0_hit  = |(w0_q & omask);
		rd_addr = (cmd.op == OP_SCAN) ? (w0_hit ? '0 : scan_sel) : tgt_word;
	end

	// Effective word read back, and the pick within it
	always_comb begin
		eff      = (t_word_q == '0) ? w0_q : (nz_rd_q ? mem_rd_q : '0);
		pick_src = eff & ((t_word_q == '0) ? omask : '1);
		pick_p   = '0;
		for (int k = 0; k < 32; k++) begin
			if (pick_src[k]) pick_p = 5'(k);
		end
		pick_any  = |pick_src;
		pick_slot = (SLOT_W'(t_word_q) << WORD_LG) | SLOT_W'(pick_p);
		pick_b    = pick_slot - (SLOT_W'(1) << (5'(POOL_ORDER) - j_q));
		pick_off  = 16'(pick_b << j_q);
		new_word  = eff;
		if (cmd.op == OP_PICK) begin
			new_word[pick_p] = 1'b0;
		end else begin
			new_word[t_bit_q] = cmd.wbit;
		end
		wr_en = (cmd.op == OP_WR) || (cmd.op == OP_PICK);
	end

	// Store words; read data registered
	always_ff @(posedge clk) begin
		if (wr_en && (t_word_q != '0)) begin
			mem[t_word_q] <= new_word;
		end
		if ((cmd.op == OP_SCAN) || (cmd.op == OP_RD)) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// Control registers: config, nonempty marks, head word, result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			bytes_q    <= POOL_LIMIT;
			nz_q       <= '0;
			w0_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.cfg_we) begin
				if (cfg_index == REG_POOL_BASE) begin
					base_q <= cfg_data;
				end else begin
					bytes_q <= (cfg_data[16:0] > POOL_LIMIT) ? POOL_LIMIT : cfg_data[16:0];
				end
			end
			if (cmd.op == OP_CARVE_INIT) begin
				nz_q <= '0;
				w0_q <= '0;
			end
			if (wr_en) begin
				nz_q[t_word_q] <= |new_word;
				if (t_word_q == '0) begin
					w0_q <= new_word;
				end
			end
			if (cmd.op == OP_RESULT) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Operand registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				cmd_q  <= s_tuser[0];
				req_q  <= s_tdata[31:0];
				addr_q <= s_tdata[63:32];
			end
			OP_DECODE: begin
				ord_q     <= dec_ord;
				ord_ok_q  <= (dec_ord <= 6'(TOP));
				j_q       <= dec_ord[4:0];
				i_q       <= dec_ord[4:0];
				lt_base_q <= (addr_q < base_q);
				off32_q   <= addr_q - base_q;
			end
			OP_CHECK: begin
				free_ok_q <= ord_ok_q && !lt_base_q && (off32_q < {15'd0, bytes_q})
					&& ((off32_q[16:0] & (pw - 17'd1)) == 17'd0)
					&& (({1'b0, off32_q[16:0]} + {1'b0, pw}) <= {1'b0, bytes_q});
				off_q     <= off32_q[15:0];
			end
			OP_CARVE_INIT: begin
				rem_q <= bytes_q;
				off_q <= '0;
			end
			OP_SCAN: begin
				t_word_q <= rd_addr;
				nz_rd_q  <= nz_q[rd_addr];
				if (!(w0_hit || scan_mem_hit)) begin
					j_q <= j_q + 5'd1;
				end
			end
			OP_PICK: begin
				off_q <= pick_off;
				i_q   <= j_q;
			end
			OP_RD: begin
				t_word_q <= tgt_word;
				t_bit_q  <= tgt_bit;
				nz_rd_q  <= nz_q[rd_addr];
			end
			OP_WR: begin
				unique case (cmd.tgt)
					TGT_CARVE: begin
						off_q <= off_q + co_pw[15:0];
						rem_q <= rem_q - co_pw;
					end
					TGT_SPLIT: i_q <= im1;
					TGT_MERGE: begin
						off_q <= off_q & ~(16'd1 << i_q);
						i_q   <= i_q + 5'd1;
					end
					default: ;
				endcase
			end
			OP_RESULT: begin
				m_status_q <= cmd.status;
				m_addr_q   <= ((cmd.status == ST_ALLOC) || (cmd.status == ST_FREED))
					? (base_q + {16'd0, off_q}) : '0;
			end
			default: ;
		endcase
	end

	// Status back to the sequencer
	always_comb begin
		stat.is_free    = (cmd_q == CMD_FREE);
		stat.ord_ok     = ord_ok_q;
		stat.free_ok    = free_ok_q;
		stat.carve_more = (rem_q >= (17'd1 << MIN_ORDER));
		stat.scan_hit   = w0_hit || scan_mem_hit;
		stat.scan_last  = (j_q == 5'(TOP));
		stat.split_more = (i_q > ord_q[4:0]);
		stat.merge_more = (i_q < 5'(TOP));
		stat.mate_free  = eff[t_bit_q];
		stat.out_busy   = m_tvalid_q && !m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_addr_q;
	assign m_tuser  = m_status_q;

	// A pick always lands on a free block of the searched order
	a_pick_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_PICK) |-> pick_any)
		else $error("pick on an empty word");

	// Never overwrite a result beat that is still waiting
	a_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RESULT) |-> !(m_tvalid_q && !m_tready))
		else $error("result register overrun");

	// Splits stop at the requested order
	a_split_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_WR && cmd.tgt == TGT_SPLIT) |-> (i_q > ord_q[4:0]))
		else $error("split below requested order");

	// Each carve step shrinks the remainder
	a_carve_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_WR && cmd.tgt == TGT_CARVE) |=> (rem_q < $past(rem_q)))
		else $error("carve remainder did not shrink");

endmodule
